FILE: rtl/mhpq_pkg.sv
// Package for the max-heap priority queue: sizes, command and status codes,
// controller states and the controller/datapath command and status structs.
`timescale 1ns / 1ps
`default_nettype none
package mhpq_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int LIMIT_W   = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_SEARCH  = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Address-select codes for the RAM port
    typedef enum logic [2:0] {
        AS_IDX,     // current index
        AS_PARENT,  // (j-1)/2
        AS_LEFT,    // 2j+1
        AS_RIGHT,   // 2j+2
        AS_SCAN,    // scan pointer
        AS_LAST,    // count-1 (after decrement: count)
        AS_BIG      // selected child
    } asel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_WR,       // increment count; j is at count
        S_UP_RDP,       // read parent
        S_UP_CMP,       // compare key vs parent
        S_UP_WRJ,       // write parent into j
        S_EX_RD0,       // read root
        S_EX_RDL,       // read last
        S_EX_WAITL,
        S_DN_RDL,       // read left child
        S_DN_RDR,       // read right child
        S_DN_WAITR,
        S_DN_CMP,
        S_DN_WRJ,       // write child into j
        S_FIN_WR,       // write moving key at final j
        S_SR_RD,
        S_SR_CMP,
        S_MN_RD,        // min scan
        S_MN_CMP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic  ram_we;
        asel_t asel;
        logic  wsel_mov;   // write moving key (1) or held data (0)
        logic  set_mov_key;      // moving key := input key
        logic  set_mov_rd;       // moving key := read data
        logic  set_val_rd;       // result value := read data
        logic  set_val_key;
        logic  clr_val;
        logic  cnt_inc;
        logic  cnt_dec;
        logic  cnt_clr;
        logic  j_zero;
        logic  j_to_cnt;
        logic  j_to_parent;
        logic  j_to_big;
        logic  hold_rd;          // hold := read data (parent/child)
        logic  lchild_cap;       // left child := read data
        logic  scan_clr;
        logic  scan_inc;
        logic  min_first;        // min := read data
        logic  min_upd;          // min := min(min, read)
        logic  min_zero;
        logic  max_cap;          // max := read data
        logic  max_zero;
        logic  set_status;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic ins_full;
        logic empty;
        logic j_root;            // j == 0
        logic up_gt;             // moving key > parent
        logic has_left;
        logic has_right;
        logic right_gt;          // right > left
        logic child_gt;          // selected child > moving key
        logic scan_done;
        logic match;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/mhpq_ram.sv
// Generic single-port RAM with registered read.
// Stand-alone; no package use.
`timescale 1ns / 1ps
`default_nettype none
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/mhpq_datapath.sv
// Datapath of the heap: key RAM, indices, count, moving key, min/max, result.
// Depends on mhpq_pkg and mhpq_ram.
`timescale 1ns / 1ps
`default_nettype none
module mhpq_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [mhpq_pkg::KEY_WIDTH-1:0] in_key,
    input  wire logic [mhpq_pkg::LIMIT_W-1:0]   limit,
    input  wire mhpq_pkg::dp_cmd_t              cmd,
    output mhpq_pkg::dp_stat_t                  stat,
    output logic [mhpq_pkg::KEY_WIDTH-1:0]      res_value,
    output logic [mhpq_pkg::STAT_W-1:0]         res_status,
    output logic [mhpq_pkg::CNT_W-1:0]          res_count,
    output logic [mhpq_pkg::KEY_WIDTH-1:0]      res_max,
    output logic [mhpq_pkg::KEY_WIDTH-1:0]      res_min
);
    import mhpq_pkg::*;

    logic [CNT_W-1:0]     cnt_reg;
    logic [ADDR_W-1:0]    j_reg, scan_reg, big_reg;
    logic [KEY_WIDTH-1:0] mov_reg, hold_reg, left_reg, val_reg, min_reg, max_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [ADDR_W-1:0]    addr, parent_idx, left_idx, right_idx, last_idx;
    logic [CNT_W:0]       left_w, right_w;
    logic [KEY_WIDTH-1:0] rdata, wdata;
    logic [CNT_W-1:0]     eff_limit;

    // index arithmetic
    assign parent_idx = (j_reg - ADDR_W'(1)) >> 1;
    assign left_w     = (CNT_W+1)'({j_reg, 1'b0}) + (CNT_W+1)'(1);
    assign right_w    = (CNT_W+1)'({j_reg, 1'b0}) + (CNT_W+1)'(2);
    assign left_idx   = left_w[ADDR_W-1:0];
    assign right_idx  = right_w[ADDR_W-1:0];
    assign last_idx   = cnt_reg[ADDR_W-1:0];

    always_comb
    begin
        unique case (cmd.asel)
            AS_IDX:    addr = j_reg;
            AS_PARENT: addr = parent_idx;
            AS_LEFT:   addr = left_idx;
            AS_RIGHT:  addr = right_idx;
            AS_SCAN:   addr = scan_reg;
            AS_LAST:   addr = last_idx;
            AS_BIG:    addr = big_reg;
            default:   addr = j_reg;
        endcase
    end

    assign wdata = cmd.wsel_mov ? mov_reg : hold_reg;

    mhpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // effective limit = min(limit, DEPTH)
    assign eff_limit = (32'(limit) < DEPTH) ? CNT_W'(limit) : CNT_W'(DEPTH);

    // status toward the controller; search compares against the captured key
    always_comb
    begin
        stat.ins_full  = (cnt_reg >= eff_limit);
        stat.empty     = (cnt_reg == '0);
        stat.j_root    = (j_reg == '0);
        stat.up_gt     = $signed(mov_reg) > $signed(rdata);
        stat.has_left  = (left_w < (CNT_W+1)'(cnt_reg));
        stat.has_right = (right_w < (CNT_W+1)'(cnt_reg));
        stat.right_gt  = $signed(rdata) > $signed(left_reg);
        stat.child_gt  = $signed(hold_reg) > $signed(mov_reg);
        stat.scan_done = ((CNT_W)'(scan_reg) + CNT_W'(1)) >= cnt_reg;
        stat.match     = (rdata == mov_reg);
    end

    // count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // result and summary registers (min starts at zero after reset)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= '0;
            max_reg    <= '0;
            val_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.min_zero)
            begin
                min_reg <= '0;
            end
            else if (cmd.min_first)
            begin
                min_reg <= rdata;
            end
            else if (cmd.min_upd && ($signed(rdata) < $signed(min_reg)))
            begin
                min_reg <= rdata;
            end
            if (cmd.max_zero)
            begin
                max_reg <= '0;
            end
            else if (cmd.max_cap)
            begin
                max_reg <= rdata;
            end
            if (cmd.clr_val)
            begin
                val_reg <= '0;
            end
            else if (cmd.set_val_rd)
            begin
                val_reg <= rdata;
            end
            else if (cmd.set_val_key)
            begin
                val_reg <= mov_reg;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.j_zero)
        begin
            j_reg <= '0;
        end
        else if (cmd.j_to_cnt)
        begin
            j_reg <= last_idx;
        end
        else if (cmd.j_to_parent)
        begin
            j_reg <= parent_idx;
        end
        else if (cmd.j_to_big)
        begin
            j_reg <= big_reg;
        end
        if (cmd.set_mov_key)
        begin
            mov_reg <= in_key;
        end
        else if (cmd.set_mov_rd)
        begin
            mov_reg <= rdata;
        end
        if (cmd.hold_rd)
        begin
            hold_reg <= rdata;
        end
        if (cmd.lchild_cap)
        begin
            left_reg <= rdata;
            hold_reg <= rdata;
            big_reg  <= left_idx;
        end
        else if (cmd.hold_rd && cmd.asel == AS_RIGHT)
        begin
            big_reg <= right_idx;
        end
        if (cmd.scan_clr)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + ADDR_W'(1);
        end
    end

    assign res_value  = val_reg;
    assign res_status = status_reg;
    assign res_count  = cnt_reg;
    assign res_max    = max_reg;
    assign res_min    = min_reg;
endmodule
`default_nettype wire

FILE: rtl/mhpq_ctrl.sv
// Controller state machine of the heap: sequences sift-up, sift-down,
// search and min scan over the single RAM port. Depends on mhpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mhpq_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [mhpq_pkg::CMD_W-1:0] in_cmd,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    input  wire mhpq_pkg::dp_stat_t         stat,
    output mhpq_pkg::dp_cmd_t               cmd
);
    import mhpq_pkg::*;

    state_t state_reg, state_next;
    logic   acc;
    logic   first_scan_reg;

    assign acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.asel   = AS_IDX;
        cmd.status = ST_OK;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (acc)
                begin
                    cmd.clr_val    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.set_mov_key = 1'b1;
                    cmd.scan_clr   = 1'b1;
                    unique case (cmd_t'(in_cmd))
                        CMD_INSERT:
                        begin
                            if (stat.ins_full)
                            begin
                                cmd.status = ST_FULL;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cmd.j_to_cnt = 1'b1;
                                state_next   = S_INS_WR;
                            end
                        end
                        CMD_EXTRACT:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cmd.j_zero = 1'b1;
                                state_next = S_EX_RD0;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                cmd.status = ST_NOTFOUND;
                                state_next = S_SR_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cmd.cnt_clr  = 1'b1;
                            cmd.min_zero = 1'b1;
                            cmd.max_zero = 1'b1;
                            state_next   = S_OUT;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            // insert: sift up from slot count by moving parents down until the key's
            // slot is found, then write the key there
            S_INS_WR:
            begin
                cmd.cnt_inc = 1'b1;
                state_next  = S_UP_RDP;
            end
            S_UP_RDP:
            begin
                if (stat.j_root)
                begin
                    state_next = S_FIN_WR;
                end
                else
                begin
                    cmd.asel   = AS_PARENT;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_gt)
                begin
                    cmd.hold_rd = 1'b1;
                    state_next  = S_UP_WRJ;
                end
                else
                begin
                    state_next = S_FIN_WR;
                end
            end
            S_UP_WRJ:
            begin
                cmd.ram_we      = 1'b1;
                cmd.asel        = AS_IDX;
                cmd.j_to_parent = 1'b1;
                state_next      = S_UP_RDP;
            end
            // extract: root out, last entry becomes the moving key
            S_EX_RD0:
            begin
                cmd.asel    = AS_IDX;
                cmd.j_zero  = 1'b1;
                cmd.cnt_dec = 1'b1;
                state_next  = S_EX_RDL;
            end
            S_EX_RDL:
            begin
                cmd.set_val_rd = 1'b1;
                cmd.asel       = AS_LAST;
                state_next     = S_EX_WAITL;
            end
            S_EX_WAITL:
            begin
                cmd.set_mov_rd = 1'b1;
                state_next     = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (stat.has_left)
                begin
                    cmd.asel   = AS_LEFT;
                    state_next = S_DN_RDR;
                end
                else
                begin
                    state_next = S_FIN_WR;
                end
            end
            S_DN_RDR:
            begin
                cmd.lchild_cap = 1'b1;
                if (stat.has_right)
                begin
                    cmd.asel   = AS_RIGHT;
                    state_next = S_DN_WAITR;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_WAITR:
            begin
                if (stat.right_gt)
                begin
                    cmd.hold_rd = 1'b1;
                    cmd.asel    = AS_RIGHT;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                state_next = stat.child_gt ? S_DN_WRJ : S_FIN_WR;
            end
            S_DN_WRJ:
            begin
                cmd.ram_we   = 1'b1;
                cmd.asel     = AS_IDX;
                cmd.j_to_big = 1'b1;
                state_next   = S_DN_RDL;
            end
            S_FIN_WR:
            begin
                cmd.ram_we   = 1'b1;
                cmd.wsel_mov = 1'b1;
                cmd.asel     = AS_IDX;
                cmd.scan_clr = 1'b1;
                state_next   = S_MN_RD;
            end
            // search scan over live entries
            S_SR_RD:
            begin
                cmd.asel   = AS_SCAN;
                state_next = S_SR_CMP;
            end
            S_SR_CMP:
            begin
                if (stat.match)
                begin
                    cmd.set_val_key = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status      = ST_OK;
                    cmd.scan_clr    = 1'b1;
                    state_next      = S_MN_RD;
                end
                else if (stat.scan_done)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_MN_RD;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SR_RD;
                end
            end
            // min and max refresh over live entries
            S_MN_RD:
            begin
                if (stat.empty)
                begin
                    cmd.min_zero = 1'b1;
                    cmd.max_zero = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.asel   = AS_SCAN;
                    state_next = S_MN_CMP;
                end
            end
            S_MN_CMP:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MN_RD;
                end
                cmd.scan_inc = 1'b1;
                // first entry of the min scan is the root: seeds min and max
                cmd.min_first = first_scan_reg;
                cmd.min_upd   = !first_scan_reg;
                cmd.max_cap   = first_scan_reg;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // marks the first entry of the min scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_scan_reg <= 1'b0;
        end
        else if (state_reg == S_MN_CMP)
        begin
            first_scan_reg <= 1'b0;
        end
        else if (state_next == S_MN_RD && state_reg != S_MN_CMP)
        begin
            first_scan_reg <= 1'b1;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/max_heap_priority_queue_top.sv
// Channel   Signals                                   Direction
// request   in_valid/in_ready, cmd, key               in
// result    out_valid/out_ready, value, status,
//           occupancy, max_value, min_value           out
// config    capacity_limit_we, capacity_limit_wdata   in
//
// One request at a time through a single-port key RAM. Insert sifts up level
// by level; extract sifts down level by level; search scans entry by entry.
// Insert, extract and search then rescan live entries for min/max; clear and
// refused requests do not. Slowest case is a search miss on a full heap. Reset
// empties the heap at once. A stalled result holds; the next request is taken
// after it leaves.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_datapath, mhpq_ram.
`timescale 1ns / 1ps
`default_nettype none
module max_heap_priority_queue_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [mhpq_pkg::CMD_W-1:0]     cmd,
    input  wire logic [mhpq_pkg::KEY_WIDTH-1:0] key,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [mhpq_pkg::KEY_WIDTH-1:0]      value,
    output logic [mhpq_pkg::STAT_W-1:0]         status,
    output logic [mhpq_pkg::LIMIT_W-1:0]        occupancy,
    output logic [mhpq_pkg::KEY_WIDTH-1:0]      max_value,
    output logic [mhpq_pkg::KEY_WIDTH-1:0]      min_value,
    input  wire logic                           capacity_limit_we,
    input  wire logic [mhpq_pkg::LIMIT_W-1:0]   capacity_limit_wdata
);
    import mhpq_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    dp_cmd_t            dcmd;
    dp_stat_t           dstat;
    logic [CNT_W-1:0]   count;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (capacity_limit_we)
        begin
            limit_reg <= capacity_limit_wdata;
        end
    end

    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dstat),
        .cmd       (dcmd)
    );

    mhpq_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_key     (key),
        .limit      (limit_reg),
        .cmd        (dcmd),
        .stat       (dstat),
        .res_value  (value),
        .res_status (status),
        .res_count  (count),
        .res_max    (max_value),
        .res_min    (min_value)
    );

    assign occupancy = LIMIT_W'(count);

    // never ready while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("ready while result pending");
    // occupancy never exceeds depth
    a_occ: assert property (@(posedge clk) disable iff (!rst_n) count <= CNT_W'(DEPTH))
        else $error("occupancy overflow");
    // an empty heap reports zero max and min
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && count == '0) |-> (max_value == '0 && min_value == '0))
        else $error("empty heap with nonzero max/min");
    // a refused insert leaves occupancy unchanged
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> $stable(count))
        else $error("refused insert changed occupancy");
endmodule
`default_nettype wire
